FILE: design/fbo_pkg.sv
// Shared types and constants for the frustum box outside test.
`timescale 1ns / 1ps

package fbo_pkg;

  localparam int CoordW   = 32;
  localparam int ProdW    = 2 * CoordW;
  // Ten Q32.32 terms of at most 63 magnitude bits each never exceed 68 signed bits.
  localparam int AccW     = ProdW + 4;
  localparam int NumCols  = 5;
  localparam int NumRows  = 3;
  localparam int NumCoef  = NumRows * NumCols;
  localparam int NumAxes  = 3;
  localparam int NumPlanes = 4;
  localparam int NumCorners = 8;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 64;
  localparam int CoefIdxW = $clog2(NumCoef);
  localparam int TransShift = 16;

  // Matrix rows and columns.
  localparam int RowX = 0;
  localparam int RowY = 1;
  localparam int RowW = 2;
  localparam int ColW = 3;
  localparam int ColT = 4;

  // Register index of the w-row translation term; lower indices hold pairs.
  localparam logic [CfgIdxW-1:0] CfgIdxTrans = 3'd7;
  localparam logic [CoefIdxW-1:0] CoefTrans = CoefIdxW'(NumCoef - 1);

  typedef logic signed [CoordW-1:0] coef_t;
  typedef coef_t coef_arr_t [NumCoef];

  typedef struct packed {
    logic                     box_unbounded;
    logic signed [CoordW-1:0] min_x;
    logic signed [CoordW-1:0] min_y;
    logic signed [CoordW-1:0] min_z;
    logic signed [CoordW-1:0] max_x;
    logic signed [CoordW-1:0] max_y;
    logic signed [CoordW-1:0] max_z;
    logic signed [CoordW-1:0] box_w;
  } box_t;

  typedef struct packed {
    logic outside;
  } result_t;

endpackage

FILE: design/fbo_box_if.sv
// Valid/ready channel carrying one bounding box word.
`timescale 1ns / 1ps

interface fbo_box_if;
  logic          valid;
  logic          ready;
  fbo_pkg::box_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: design/fbo_result_if.sv
// Valid/ready channel carrying one culling result word.
`timescale 1ns / 1ps

interface fbo_result_if;
  logic             valid;
  logic             ready;
  fbo_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: design/frustum_box_outside_test_top.sv
// A box's result word is valid once the box has passed all the stages listed below, in order.
// Throughput: one box per cycle; a stalled output holds the pipeline stage by stage,
// and empty stages keep filling, so bubbles close up while the result waits.
// Stages: input, products, plane terms, partial corner sums, corner tests.
// Reset (synchronous, active low) empties the pipeline and clears every coefficient.
`timescale 1ns / 1ps

module frustum_box_outside_test_top (
  input  logic                         clk,
  input  logic                         rst_n,
  fbo_box_if.sink                      in_box,
  fbo_result_if.source                 out_res,
  input  logic                         cfg_we,
  input  logic [fbo_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [fbo_pkg::CfgDataW-1:0] cfg_data
);

  localparam int ProdW = fbo_pkg::ProdW;
  localparam int AccW  = fbo_pkg::AccW;

  fbo_pkg::coef_arr_t coef;

  fbo_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coef      (coef)
  );

  // Stage valid bits and per-stage load enables.
  logic v1_r, v2_r, v3_r, v4_r, out_v_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5 = !out_v_r || out_res.ready;
  assign rdy4 = !v4_r || rdy5;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      v4_r    <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (rdy1) v1_r    <= in_box.valid;
      if (rdy2) v2_r    <= v1_r;
      if (rdy3) v3_r    <= v2_r;
      if (rdy4) v4_r    <= v3_r;
      if (rdy5) out_v_r <= v4_r;
    end
  end

  // Stage 1: input word.
  fbo_pkg::box_t box1_r;

  always_ff @(posedge clk) begin
    if (rdy1) box1_r <= in_box.data;
  end

  // Stage 2: every coefficient product, last index 0 for the minimum and 1 for the maximum.
  logic signed [ProdW-1:0] prod_nxt [fbo_pkg::NumRows][fbo_pkg::NumAxes][2];
  logic signed [ProdW-1:0] prod_r   [fbo_pkg::NumRows][fbo_pkg::NumAxes][2];
  logic signed [ProdW-1:0] pw_nxt   [fbo_pkg::NumRows];
  logic signed [ProdW-1:0] pw_r     [fbo_pkg::NumRows];
  logic signed [ProdW-1:0] pt_nxt   [fbo_pkg::NumRows];
  logic signed [ProdW-1:0] pt_r     [fbo_pkg::NumRows];
  logic                    unb2_r;
  logic signed [fbo_pkg::CoordW-1:0] pt_lo [fbo_pkg::NumAxes];
  logic signed [fbo_pkg::CoordW-1:0] pt_hi [fbo_pkg::NumAxes];

  assign pt_lo[0] = box1_r.min_x;
  assign pt_lo[1] = box1_r.min_y;
  assign pt_lo[2] = box1_r.min_z;
  assign pt_hi[0] = box1_r.max_x;
  assign pt_hi[1] = box1_r.max_y;
  assign pt_hi[2] = box1_r.max_z;

  always_comb begin
    for (int r = 0; r < fbo_pkg::NumRows; r++) begin
      for (int a = 0; a < fbo_pkg::NumAxes; a++) begin
        prod_nxt[r][a][0] = ProdW'(coef[r * fbo_pkg::NumCols + a]) * ProdW'(pt_lo[a]);
        prod_nxt[r][a][1] = ProdW'(coef[r * fbo_pkg::NumCols + a]) * ProdW'(pt_hi[a]);
      end
      pw_nxt[r] = ProdW'(coef[r * fbo_pkg::NumCols + fbo_pkg::ColW]) * ProdW'(box1_r.box_w);
      // The translation term is Q16.16 and is brought to Q32.32.
      pt_nxt[r] = ProdW'(coef[r * fbo_pkg::NumCols + fbo_pkg::ColT]) <<< fbo_pkg::TransShift;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      prod_r <= prod_nxt;
      pw_r   <= pw_nxt;
      pt_r   <= pt_nxt;
      unb2_r <= box1_r.box_unbounded;
    end
  end

  // Stage 3: per side plane, the row plus or minus the w row, axis by axis.
  // Planes in order: x+w<0, x-w>0, y+w<0, y-w>0.
  logic signed [AccW-1:0] term_nxt  [fbo_pkg::NumPlanes][fbo_pkg::NumAxes][2];
  logic signed [AccW-1:0] term_r    [fbo_pkg::NumPlanes][fbo_pkg::NumAxes][2];
  logic signed [AccW-1:0] const_nxt [fbo_pkg::NumPlanes];
  logic signed [AccW-1:0] const_r   [fbo_pkg::NumPlanes];
  logic                   unb3_r;

  always_comb begin
    int row;
    logic sub;
    for (int p = 0; p < fbo_pkg::NumPlanes; p++) begin
      row = (p < 2) ? fbo_pkg::RowX : fbo_pkg::RowY;
      sub = ((p & 1) != 0);
      for (int a = 0; a < fbo_pkg::NumAxes; a++) begin
        for (int s = 0; s < 2; s++) begin
          term_nxt[p][a][s] = sub
            ? AccW'(prod_r[row][a][s]) - AccW'(prod_r[fbo_pkg::RowW][a][s])
            : AccW'(prod_r[row][a][s]) + AccW'(prod_r[fbo_pkg::RowW][a][s]);
        end
      end
      const_nxt[p] = sub
        ? AccW'(pw_r[row]) + AccW'(pt_r[row])
          - AccW'(pw_r[fbo_pkg::RowW]) - AccW'(pt_r[fbo_pkg::RowW])
        : AccW'(pw_r[row]) + AccW'(pt_r[row])
          + AccW'(pw_r[fbo_pkg::RowW]) + AccW'(pt_r[fbo_pkg::RowW]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      term_r  <= term_nxt;
      const_r <= const_nxt;
      unb3_r  <= unb2_r;
    end
  end

  // Stage 4: x term with the constant part, and the four y and z combinations.
  logic signed [AccW-1:0] xc_nxt [fbo_pkg::NumPlanes][2];
  logic signed [AccW-1:0] xc_r   [fbo_pkg::NumPlanes][2];
  logic signed [AccW-1:0] yz_nxt [fbo_pkg::NumPlanes][4];
  logic signed [AccW-1:0] yz_r   [fbo_pkg::NumPlanes][4];
  logic                   unb4_r;

  always_comb begin
    for (int p = 0; p < fbo_pkg::NumPlanes; p++) begin
      for (int i = 0; i < 2; i++) begin
        xc_nxt[p][i] = term_r[p][0][i] + const_r[p];
      end
      for (int j = 0; j < 4; j++) begin
        yz_nxt[p][j] = term_r[p][1][j & 1] + term_r[p][2][(j >> 1) & 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      xc_r   <= xc_nxt;
      yz_r   <= yz_nxt;
      unb4_r <= unb3_r;
    end
  end

  // Stage 5: the eight corner sums of each plane and the verdict.
  logic outside_nxt;
  logic outside_r;

  always_comb begin
    logic signed [AccW-1:0] sum;
    logic all_beyond;
    logic beyond;
    logic any_plane;
    any_plane = 1'b0;
    for (int p = 0; p < fbo_pkg::NumPlanes; p++) begin
      all_beyond = 1'b1;
      for (int c = 0; c < fbo_pkg::NumCorners; c++) begin
        sum = xc_r[p][c & 1] + yz_r[p][(c >> 1) & 3];
        // A corner exactly on the plane is not beyond it.
        if ((p & 1) != 0) beyond = !sum[AccW-1] && (sum != '0);
        else              beyond = sum[AccW-1];
        all_beyond = all_beyond && beyond;
      end
      any_plane = any_plane || all_beyond;
    end
    outside_nxt = any_plane && !unb4_r;
  end

  always_ff @(posedge clk) begin
    if (rdy5) outside_r <= outside_nxt;
  end

  assign in_box.ready         = rdy1;
  assign out_res.valid        = out_v_r;
  assign out_res.data.outside = outside_r;

  // An unbounded box always yields a clear verdict.
  a_unbounded_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && unb4_r && rdy5) |=> (out_res.valid && !out_res.data.outside))
    else $error("unbounded box reported outside");

  // The input can only be held off when a result word waits at the output.
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_box.ready |-> (out_res.valid && !out_res.ready))
    else $error("input held off without an output stall");

  // A stalled output freezes the stage behind it.
  a_stage4_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && !rdy5) |=> (v4_r && $stable(unb4_r)))
    else $error("stage four lost its word during a stall");

endmodule

FILE: design/fbo_cfg_regs.sv
// Clip matrix coefficient registers behind the configuration write port.
`timescale 1ns / 1ps

module fbo_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [fbo_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [fbo_pkg::CfgDataW-1:0]   cfg_data,
  output fbo_pkg::coef_arr_t             coef
);

  fbo_pkg::coef_arr_t coef_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < fbo_pkg::NumCoef; i++) begin
        coef_r[i] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        fbo_pkg::CfgIdxTrans: begin
          coef_r[fbo_pkg::CoefTrans] <= cfg_data[fbo_pkg::CoordW-1:0];
        end
        default: begin
          // A pair register holds the even coefficient low and the odd one high.
          coef_r[{cfg_index, 1'b0}] <= cfg_data[fbo_pkg::CoordW-1:0];
          coef_r[{cfg_index, 1'b1}] <= cfg_data[fbo_pkg::CfgDataW-1:fbo_pkg::CoordW];
        end
      endcase
    end
  end

  assign coef = coef_r;

endmodule

FILE: test/tb_frustum_box_outside_test_top.sv
// Self-checking testbench for the clip-space box culling block, with its own exact predictor.
`timescale 1ns / 1ps

module tb_frustum_box_outside_test_top;
  import fbo_pkg::*;

  localparam int One        = 32'h0001_0000;
  localparam int CycleLimit = 400000;
  localparam int RandPerPhase = 110;

  typedef logic signed [127:0] acc_t;

  typedef enum {
    MatIdentity, MatPerspective, MatSmallRandom, MatFullRandom, MatMaxPos, MatMaxNeg
  } mat_kind_e;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  fbo_box_if    box_ch ();
  fbo_result_if res_ch ();

  frustum_box_outside_test_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_box   (box_ch),
    .out_res  (res_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  coef_t     clip_coef [NumCoef];
  coef_arr_t next_mat;
  bit        expected_outside [$];
  bit        want_outside;
  int        send_idle_pct;
  int        recv_stall_pct;
  int        hold_left;
  int        fail_count;
  int        boxes_sent;
  int        culled_seen;
  int        matrices_loaded;
  int        cycle_count;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // The receiver counts down its own long hold-off before going back to random stalls.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      res_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (expected_outside.size() == 0) begin
        $error("result word with no box waiting: outside=%0b", res_ch.data.outside);
        fail_count++;
      end else begin
        want_outside = expected_outside.pop_front();
        if (res_ch.data.outside !== want_outside) begin
          $error("outside: expected %0b, got %0b", want_outside, res_ch.data.outside);
          fail_count++;
        end
      end
      if (res_ch.data.outside === 1'b1) culled_seen++;
    end
  end

  // One matrix row applied to one corner, kept exact in Q32.32.
  function automatic acc_t row_value(input int row, input coef_t px, input coef_t py,
                                     input coef_t pz, input coef_t pw);
    return acc_t'(clip_coef[row*NumCols + 0]) * acc_t'(px)
         + acc_t'(clip_coef[row*NumCols + 1]) * acc_t'(py)
         + acc_t'(clip_coef[row*NumCols + 2]) * acc_t'(pz)
         + acc_t'(clip_coef[row*NumCols + ColW]) * acc_t'(pw)
         + (acc_t'(clip_coef[row*NumCols + ColT]) <<< TransShift);
  endfunction

  function automatic bit predict_outside(input box_t b);
    logic [NumPlanes-1:0] all_beyond;
    coef_t px, py, pz;
    acc_t  cx, cy, cw;
    int    c;
    if (b.box_unbounded) return 1'b0;
    all_beyond = '1;
    for (c = 0; c < NumCorners; c++) begin
      px = c[0] ? b.max_x : b.min_x;
      py = c[1] ? b.max_y : b.min_y;
      pz = c[2] ? b.max_z : b.min_z;
      cx = row_value(RowX, px, py, pz, b.box_w);
      cy = row_value(RowY, px, py, pz, b.box_w);
      cw = row_value(RowW, px, py, pz, b.box_w);
      // A sum of exactly zero lies on the plane and does not count as beyond it.
      all_beyond &= {cy - cw > 0, cy + cw < 0, cx - cw > 0, cx + cw < 0};
    end
    return |all_beyond;
  endfunction

  function automatic void set_coef_reg(input logic [CfgIdxW-1:0] idx,
                                       input logic [CfgDataW-1:0] val);
    if (idx == CfgIdxTrans) begin
      clip_coef[CoefTrans] = val[31:0];
    end else begin
      clip_coef[2*idx]     = val[31:0];
      clip_coef[2*idx + 1] = val[63:32];
    end
  endfunction

  task automatic cfg_put(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    set_coef_reg(idx, val);
  endtask

  // Writes every register; the translation register also gets junk in its unused upper half.
  task automatic load_matrix();
    int i;
    for (i = 0; i < NumCoef / 2; i++)
      cfg_put(CfgIdxW'(i), {next_mat[2*i + 1], next_mat[2*i]});
    cfg_put(CfgIdxTrans, {$urandom, next_mat[CoefTrans]});
    @(negedge clk);
    cfg_we <= 1'b0;
    matrices_loaded++;
  endtask

  task automatic build_matrix(input mat_kind_e kind);
    int k;
    for (k = 0; k < NumCoef; k++) begin
      case (kind)
        MatSmallRandom: next_mat[k] = $signed($urandom_range(4*One)) - 2*One;
        MatFullRandom:  next_mat[k] = $urandom;
        MatMaxPos:      next_mat[k] = 32'h7FFF_FFFF;
        MatMaxNeg:      next_mat[k] = 32'h8000_0000;
        default:        next_mat[k] = '0;
      endcase
    end
    if (kind == MatIdentity) begin
      next_mat[RowX*NumCols + 0]    = One;
      next_mat[RowY*NumCols + 1]    = One;
      next_mat[RowW*NumCols + ColW] = One;
    end else if (kind == MatPerspective) begin
      next_mat[RowX*NumCols + 0]    = One + One / 2;
      next_mat[RowX*NumCols + ColT] = One / 4;
      next_mat[RowY*NumCols + 1]    = 2 * One;
      next_mat[RowY*NumCols + 2]    = -(One / 8);
      next_mat[RowW*NumCols + 2]    = -One;
      next_mat[RowW*NumCols + ColW] = One / 2;
      next_mat[RowW*NumCols + ColT] = One;
    end
  endtask

  task automatic send_box(input box_t b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      box_ch.valid <= 1'b0;
      @(negedge clk);
    end
    box_ch.valid <= 1'b1;
    box_ch.data  <= b;
    do @(posedge clk); while (!box_ch.ready);
    expected_outside.push_back(predict_outside(b));
    boxes_sent++;
  endtask

  // Drops valid, waits for every result word, then lets the pipeline run dry.
  task automatic settle();
    @(negedge clk);
    box_ch.valid <= 1'b0;
    while (expected_outside.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic box_t mk_box(input bit unb, input int mnx, input int mny,
                                  input int mnz, input int mxx, input int mxy,
                                  input int mxz, input int w);
    box_t b;
    b.box_unbounded = unb;
    b.min_x = mnx; b.min_y = mny; b.min_z = mnz;
    b.max_x = mxx; b.max_y = mxy; b.max_z = mxz;
    b.box_w = w;
    return b;
  endfunction

  // Sometimes lands exactly on plus or minus one so that corners sit on a plane.
  function automatic int rand_coord(input int span);
    if ($urandom_range(9) == 0) return $urandom_range(1) ? One : -One;
    return $signed($urandom_range(2*span)) - span;
  endfunction

  function automatic box_t rand_box();
    box_t b;
    int   span;
    if ($urandom_range(99) < 20) begin
      b.box_unbounded = 1'($urandom_range(1));
      b.min_x = $urandom; b.min_y = $urandom; b.min_z = $urandom;
      b.max_x = $urandom; b.max_y = $urandom; b.max_z = $urandom;
      b.box_w = $urandom;
      return b;
    end
    span = One << $urandom_range(3);
    b.box_unbounded = ($urandom_range(99) < 5);
    b.min_x = rand_coord(span); b.max_x = rand_coord(span);
    b.min_y = rand_coord(span); b.max_y = rand_coord(span);
    b.min_z = rand_coord(span); b.max_z = rand_coord(span);
    case ($urandom_range(9))
      6, 7:    b.box_w = $urandom_range(4*One, One / 4);
      8:       b.box_w = rand_coord(span);
      9:       b.box_w = 0;
      default: b.box_w = One;
    endcase
    return b;
  endfunction

  task automatic test_reset_matrix();
    // All coefficients are zero after reset, so every sum is zero and nothing is culled.
    send_box(mk_box(0, -3*One, -One/2, 0, -2*One, One/2, One, One));
    send_box(mk_box(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_box(mk_box(1, 2*One, 2*One, 2*One, 3*One, 3*One, 3*One, One));
    settle();
  endtask

  task automatic test_plane_cases();
    build_matrix(MatIdentity);
    load_matrix();
    send_box(mk_box(0, -3*One, -One/2, 0, -2*One, One/2, One, One));
    send_box(mk_box(0, 2*One, -One/2, 0, 3*One, One/2, One, One));
    send_box(mk_box(0, -One/2, -3*One, 0, One/2, -2*One, One, One));
    send_box(mk_box(0, -One/2, 2*One, 0, One/2, 3*One, One, One));
    send_box(mk_box(0, -One/2, -One/2, -One/2, One/2, One/2, One/2, One));
    send_box(mk_box(0, -3*One, -One/2, 0, 3*One, One/2, One, One));
    // Corners lying exactly on a side plane.
    send_box(mk_box(0, -3*One, -One/2, 0, -One, One/2, One, One));
    send_box(mk_box(0, One, -One/2, 0, 3*One, One/2, One, One));
    send_box(mk_box(0, -One/2, -3*One, 0, One/2, -One, One, One));
    send_box(mk_box(1, -3*One, -One/2, 0, -2*One, One/2, One, One));
    // Minimum above maximum is taken as given.
    send_box(mk_box(0, -2*One, One/2, One, -3*One, -One/2, 0, One));
    send_box(mk_box(0, -One/2, -One/2, 0, One/2, One/2, One, -One));
    send_box(mk_box(0, One/2, -One/2, 0, One, One/2, One, 0));
    send_box(mk_box(0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_box(mk_box(0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    settle();
  endtask

  task automatic test_extreme_matrix();
    int m;
    for (m = 0; m < 2; m++) begin
      build_matrix(m == 0 ? MatMaxPos : MatMaxNeg);
      load_matrix();
      send_box(mk_box(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
      send_box(mk_box(0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
      send_box(mk_box(0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
      settle();
    end
  endtask

  task automatic test_random_streams();
    mat_kind_e kinds [4];
    int idle_set [4];
    int stall_set [4];
    int m, p, n;
    kinds     = '{MatIdentity, MatPerspective, MatSmallRandom, MatFullRandom};
    idle_set  = '{0, 61, 0, 20};
    stall_set = '{0, 0, 61, 20};
    for (m = 0; m < 4; m++) begin
      build_matrix(kinds[m]);
      load_matrix();
      for (p = 0; p < 4; p++) begin
        send_idle_pct  = idle_set[p];
        recv_stall_pct = stall_set[p];
        for (n = 0; n < RandPerPhase; n++) send_box(rand_box());
      end
      settle();
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  // The receiver holds off long enough for the pipeline to fill and refuse boxes.
  task automatic test_backpressure();
    int n;
    build_matrix(MatIdentity);
    load_matrix();
    hold_left = 300;
    for (n = 0; n < 60; n++) send_box(rand_box());
    settle();
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    box_ch.valid   = 1'b0;
    box_ch.data    = '0;
    res_ch.ready   = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 0;
    fail_count     = 0;
    boxes_sent     = 0;
    culled_seen    = 0;
    matrices_loaded = 0;
    cycle_count    = 0;
    foreach (clip_coef[k]) clip_coef[k] = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_matrix();
    test_plane_cases();
    test_extreme_matrix();
    test_random_streams();
    test_backpressure();

    if (expected_outside.size() != 0) begin
      $error("%0d result words never arrived", expected_outside.size());
      fail_count++;
    end
    $display("Checked %0d boxes under %0d coefficient sets, %0d of them culled,",
             boxes_sent, matrices_loaded, culled_seen);
    $display("with sender gaps, receiver stalls and one long output hold-off.");
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
